/* design/phc_pkg.sv */
// shared types and codes for the polygon hit test block
package phc_pkg;

  // command codes carried in the kind field
  localparam logic [2:0] KIND_APPEND  = 3'd0;
  localparam logic [2:0] KIND_REMOVE  = 3'd1;
  localparam logic [2:0] KIND_ROTATE  = 3'd2;
  localparam logic [2:0] KIND_POINT   = 3'd3;
  localparam logic [2:0] KIND_COLLIDE = 3'd4;

  // result status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_POS_A_X = 2'd0;
  localparam logic [1:0] REG_POS_A_Y = 2'd1;
  localparam logic [1:0] REG_POS_B_X = 2'd2;
  localparam logic [1:0] REG_POS_B_Y = 2'd3;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ROT,
    ST_ROT_DRAIN,
    ST_CPHASE,
    ST_SRC_RD,
    ST_SRC_LATCH,
    ST_WALK,
    ST_WALK_WAIT,
    ST_FINISH
  } state_t;

  // control travelling with each vertex read into the edge pipeline
  typedef struct packed {
    logic vld;
    logic first;
    logic last;
  } walk_ctl_t;

endpackage

/* design/polygon_hit_test_core.sv */
// top level of the polygon hit test block
// append, remove and unused kinds go straight to the result register; rotate and point
// test walk the N stored vertices; collide walks one polygon once per vertex of the
// other, both ways, stopping at the first hit, with all reads on the single memory read port
// one item at a time: next input transfer the cycle after the result register loads
// synchronous reset empties both polygons and zeroes the positions; no clearing pass
module polygon_hit_test_core #(
  parameter int MAX_VERTICES = 16,
  parameter int COORD_WIDTH  = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // coord_x, coord_y, cos_of_angle, sin_of_angle
  input  logic [3:0]  s_tuser,   // kind, which_polygon
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // hit, status, vertex_count
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int IW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);
  localparam int AW = IW + 1;
  localparam int AB = ((COORD_WIDTH > 16) ? COORD_WIDTH : 16) + 1;
  localparam longint CHI = (longint'(1) <<< (COORD_WIDTH - 1)) - 1;
  localparam longint CLO = -CHI - 1;

  phc_pkg::state_t state, state_next;

  logic        [2:0]  in_kind;
  logic               in_sel;
  logic signed [15:0] in_x, in_y, in_cs, in_sn;
  logic               acc_in;

  logic signed [15:0] pos_ax, pos_ay, pos_bx, pos_by;
  logic [CW-1:0]      cnt_a, cnt_b, n_sel, n_src, n_dst, n_op;

  logic [2:0]         op_kind;
  logic               op_sel;
  logic signed [15:0] cs, sn;
  logic [CW-1:0]      wk, k, walk_n, widx;
  logic               phase, acc_hit, walk_sel;
  logic               res_hit;
  logic [1:0]         res_status;
  logic signed [AB-1:0] pt_x, pt_y, abs_x, abs_y;

  logic [AW-1:0]      rd_addr, wr_addr;
  logic [2*COORD_WIDTH-1:0] rd_data, wr_data;
  logic               mem_we, rd_sel_d;
  logic signed [COORD_WIDTH-1:0] rd_x, rd_y, ap_x, ap_y;

  logic               walk_issue, rot_issue, rot_vld_d;
  logic [IW-1:0]      rot_idx_d;
  phc_pkg::walk_ctl_t ctl_d;
  logic               e_done, e_hit;
  logic               rw_vld, rot_busy;
  logic [IW-1:0]      rw_idx;
  logic [COORD_WIDTH-1:0] rw_x, rw_y;
  logic               full, empty;

  // input fields
  assign in_kind = s_tuser[2:0];
  assign in_sel  = s_tuser[3];
  assign in_x    = s_tdata[15:0];
  assign in_y    = s_tdata[31:16];
  assign in_cs   = s_tdata[47:32];
  assign in_sn   = s_tdata[63:48];
  assign acc_in  = s_tvalid && s_tready;
  assign s_tready  = (state == phc_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;

  // counts of selected, source and target polygons
  assign n_sel = in_sel ? cnt_b : cnt_a;
  assign n_op  = op_sel ? cnt_b : cnt_a;
  assign n_src = phase ? cnt_a : cnt_b;
  assign n_dst = phase ? cnt_b : cnt_a;
  assign full  = (n_sel >= CW'(MAX_VERTICES));
  assign empty = (n_sel == '0);

  // appended offset saturated to the stored width
  always_comb begin
    if (longint'(in_x) > CHI) begin
      ap_x = COORD_WIDTH'(CHI);
    end else if (longint'(in_x) < CLO) begin
      ap_x = COORD_WIDTH'(CLO);
    end else begin
      ap_x = COORD_WIDTH'(in_x);
    end
    if (longint'(in_y) > CHI) begin
      ap_y = COORD_WIDTH'(CHI);
    end else if (longint'(in_y) < CLO) begin
      ap_y = COORD_WIDTH'(CLO);
    end else begin
      ap_y = COORD_WIDTH'(in_y);
    end
  end

  // absolute position of the vertex just read
  assign rd_x  = rd_data[COORD_WIDTH-1:0];
  assign rd_y  = rd_data[2*COORD_WIDTH-1:COORD_WIDTH];
  assign abs_x = AB'(rd_x) + AB'(rd_sel_d ? pos_bx : pos_ax);
  assign abs_y = AB'(rd_y) + AB'(rd_sel_d ? pos_by : pos_ay);

  // walk order: last vertex first, then 0 .. n-1
  assign widx = (wk == '0) ? (walk_n - CW'(1)) : (wk - CW'(1));

  // memory write: append or rotation write back
  always_comb begin
    mem_we  = 1'b0;
    wr_addr = {in_sel, n_sel[IW-1:0]};
    wr_data = {ap_y, ap_x};
    if (acc_in && in_kind == phc_pkg::KIND_APPEND && !full) begin
      mem_we = 1'b1;
    end else if (rw_vld) begin
      mem_we  = 1'b1;
      wr_addr = {op_sel, rw_idx};
      wr_data = {rw_y, rw_x};
    end
  end

  phc_vmem #(.AW(AW), .DW(2 * COORD_WIDTH)) u_vmem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  phc_rot #(.CWID(COORD_WIDTH), .IW(IW)) u_rot (
    .clk    (clk),
    .rst    (rst),
    .in_vld (rot_vld_d),
    .in_idx (rot_idx_d),
    .x      (rd_x),
    .y      (rd_y),
    .cs     (cs),
    .sn     (sn),
    .wr_vld (rw_vld),
    .wr_idx (rw_idx),
    .wr_x   (rw_x),
    .wr_y   (rw_y),
    .busy   (rot_busy)
  );

  phc_edge #(.AB(AB)) u_edge (
    .clk  (clk),
    .rst  (rst),
    .ctl  (ctl_d),
    .vx   (abs_x),
    .vy   (abs_y),
    .px   (pt_x),
    .py   (pt_y),
    .done (e_done),
    .hit  (e_hit)
  );

  // next state and read address
  always_comb begin
    state_next = state;
    rd_addr    = {walk_sel, widx[IW-1:0]};
    walk_issue = 1'b0;
    rot_issue  = 1'b0;
    case (state)
      phc_pkg::ST_IDLE: begin
        if (acc_in) begin
          case (in_kind)
            phc_pkg::KIND_ROTATE:  state_next = empty ? phc_pkg::ST_FINISH : phc_pkg::ST_ROT;
            phc_pkg::KIND_POINT:   state_next = empty ? phc_pkg::ST_FINISH : phc_pkg::ST_WALK;
            phc_pkg::KIND_COLLIDE: state_next = phc_pkg::ST_CPHASE;
            default:               state_next = phc_pkg::ST_FINISH;
          endcase
        end
      end
      phc_pkg::ST_ROT: begin
        rd_addr   = {op_sel, wk[IW-1:0]};
        rot_issue = 1'b1;
        if (wk == walk_n - CW'(1)) begin
          state_next = phc_pkg::ST_ROT_DRAIN;
        end
      end
      phc_pkg::ST_ROT_DRAIN: begin
        if (!rot_vld_d && !rot_busy) begin
          state_next = phc_pkg::ST_FINISH;
        end
      end
      phc_pkg::ST_CPHASE: begin
        if (acc_hit) begin
          state_next = phc_pkg::ST_FINISH;
        end else if (k >= n_src || n_dst == '0) begin
          if (phase) begin
            state_next = phc_pkg::ST_FINISH;
          end
        end else begin
          state_next = phc_pkg::ST_SRC_RD;
        end
      end
      phc_pkg::ST_SRC_RD: begin
        rd_addr    = {!phase, k[IW-1:0]};
        state_next = phc_pkg::ST_SRC_LATCH;
      end
      phc_pkg::ST_SRC_LATCH: begin
        state_next = phc_pkg::ST_WALK;
      end
      phc_pkg::ST_WALK: begin
        walk_issue = 1'b1;
        if (wk == walk_n) begin
          state_next = phc_pkg::ST_WALK_WAIT;
        end
      end
      phc_pkg::ST_WALK_WAIT: begin
        if (e_done) begin
          state_next = (op_kind == phc_pkg::KIND_POINT) ? phc_pkg::ST_FINISH
                                                        : phc_pkg::ST_CPHASE;
        end
      end
      phc_pkg::ST_FINISH: begin
        if (!m_tvalid || m_tready) begin
          state_next = phc_pkg::ST_IDLE;
        end
      end
      default: state_next = phc_pkg::ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= phc_pkg::ST_IDLE;
      cnt_a     <= '0;
      cnt_b     <= '0;
      pos_ax    <= '0;
      pos_ay    <= '0;
      pos_bx    <= '0;
      pos_by    <= '0;
      m_tvalid  <= 1'b0;
      rot_vld_d <= 1'b0;
      ctl_d     <= '0;
    end else begin
      state     <= state_next;
      rot_vld_d <= rot_issue;
      ctl_d.vld   <= walk_issue;
      ctl_d.first <= (wk == '0);
      ctl_d.last  <= (wk == walk_n);
      // configuration transfer
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          phc_pkg::REG_POS_A_X: pos_ax <= cfg_data;
          phc_pkg::REG_POS_A_Y: pos_ay <= cfg_data;
          phc_pkg::REG_POS_B_X: pos_bx <= cfg_data;
          phc_pkg::REG_POS_B_Y: pos_by <= cfg_data;
          default: ;
        endcase
      end
      // append and remove update the count at once
      if (acc_in && in_kind == phc_pkg::KIND_APPEND && !full) begin
        if (in_sel) cnt_b <= cnt_b + CW'(1);
        else        cnt_a <= cnt_a + CW'(1);
      end
      if (acc_in && in_kind == phc_pkg::KIND_REMOVE && !empty) begin
        if (in_sel) cnt_b <= cnt_b - CW'(1);
        else        cnt_a <= cnt_a - CW'(1);
      end
      // result register
      if (state == phc_pkg::ST_FINISH && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // operation datapath
  always_ff @(posedge clk) begin
    rd_sel_d  <= rd_addr[AW-1];
    rot_idx_d <= rd_addr[IW-1:0];
    if (acc_in) begin
      op_kind    <= in_kind;
      op_sel     <= in_sel;
      cs         <= in_cs;
      sn         <= in_sn;
      wk         <= '0;
      k          <= '0;
      phase      <= 1'b0;
      acc_hit    <= 1'b0;
      res_hit    <= 1'b0;
      walk_sel   <= in_sel;
      walk_n     <= n_sel;
      pt_x       <= AB'(in_x);
      pt_y       <= AB'(in_y);
      if (in_kind == phc_pkg::KIND_APPEND && full) begin
        res_status <= phc_pkg::STAT_FULL;
      end else if (in_kind == phc_pkg::KIND_REMOVE && empty) begin
        res_status <= phc_pkg::STAT_EMPTY;
      end else begin
        res_status <= phc_pkg::STAT_OK;
      end
    end
    case (state)
      phc_pkg::ST_ROT, phc_pkg::ST_WALK: begin
        wk <= wk + CW'(1);
      end
      phc_pkg::ST_CPHASE: begin
        res_hit <= acc_hit;
        if (!acc_hit && (k >= n_src || n_dst == '0) && !phase) begin
          phase <= 1'b1;
          k     <= '0;
        end
      end
      phc_pkg::ST_SRC_LATCH: begin
        pt_x     <= abs_x;
        pt_y     <= abs_y;
        wk       <= '0;
        walk_sel <= phase;
        walk_n   <= n_dst;
      end
      phc_pkg::ST_WALK_WAIT: begin
        if (e_done) begin
          if (op_kind == phc_pkg::KIND_POINT) begin
            res_hit <= e_hit;
          end else begin
            acc_hit <= acc_hit | e_hit;
            k       <= k + CW'(1);
          end
        end
      end
      phc_pkg::ST_FINISH: begin
        if (!m_tvalid || m_tready) begin
          m_tdata <= {5'(n_op), res_status, res_hit};
        end
      end
      default: ;
    endcase
  end

endmodule

/* design/phc_vmem.sv */
// vertex memory: one write port, one registered read port
module phc_vmem #(
  parameter int AW = 5,
  parameter int DW = 32
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [0:(1 << AW)-1];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* design/phc_rot.sv */
// rotation datapath: multiply stage, then round, saturate and write back
module phc_rot #(
  parameter int CWID = 16,
  parameter int IW   = 4
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_vld,
  input  logic [IW-1:0]          in_idx,
  input  logic signed [CWID-1:0] x,
  input  logic signed [CWID-1:0] y,
  input  logic signed [15:0]     cs,
  input  logic signed [15:0]     sn,
  output logic                   wr_vld,
  output logic [IW-1:0]          wr_idx,
  output logic [CWID-1:0]        wr_x,
  output logic [CWID-1:0]        wr_y,
  output logic                   busy
);

  localparam int PW = CWID + 16;
  localparam int RW = PW + 2;
  localparam longint HI = (longint'(1) <<< (CWID - 1)) - 1;
  localparam longint LO = -HI - 1;

  logic              s1_vld;
  logic [IW-1:0]     s1_idx;
  logic signed [PW-1:0] xc, ys, xs, yc;
  logic signed [RW-1:0] sum_x, sum_y, sh_x, sh_y;

  // products
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else begin
      s1_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    s1_idx <= in_idx;
    xc <= x * cs;
    ys <= y * sn;
    xs <= x * sn;
    yc <= y * cs;
  end

  // round to nearest, ties up, then saturate
  always_comb begin
    sum_x = RW'(xc) - RW'(ys) + RW'(8192);
    sum_y = RW'(xs) + RW'(yc) + RW'(8192);
    sh_x  = sum_x >>> 14;
    sh_y  = sum_y >>> 14;
    if (sh_x > HI) begin
      wr_x = CWID'(HI);
    end else if (sh_x < LO) begin
      wr_x = CWID'(LO);
    end else begin
      wr_x = CWID'(sh_x);
    end
    if (sh_y > HI) begin
      wr_y = CWID'(HI);
    end else if (sh_y < LO) begin
      wr_y = CWID'(LO);
    end else begin
      wr_y = CWID'(sh_y);
    end
  end

  assign wr_vld = s1_vld;
  assign wr_idx = s1_idx;
  assign busy   = s1_vld;

endmodule

/* design/phc_edge.sv */
// crossing-number edge pipeline: span test, cross products, compare and parity
module phc_edge #(
  parameter int AB = 17
) (
  input  logic                  clk,
  input  logic                  rst,
  input  phc_pkg::walk_ctl_t    ctl,
  input  logic signed [AB-1:0]  vx,
  input  logic signed [AB-1:0]  vy,
  input  logic signed [AB-1:0]  px,
  input  logic signed [AB-1:0]  py,
  output logic                  done,
  output logic                  hit
);

  localparam int DW = AB + 1;
  localparam int MW = 2 * DW;

  logic signed [AB-1:0] xj, yj;
  logic                 e1_vld, e1_last, e1_cond, e1_dpos, e1_dneg;
  logic signed [DW-1:0] e1_a, e1_b, e1_c, e1_d;
  logic                 e2_vld, e2_last, e2_cond, e2_dpos, e2_dneg;
  logic signed [MW-1:0] e2_p1, e2_p2;
  logic                 odd, tog, cond;

  // span test on the incoming edge (current vertex i, previous vertex j)
  assign cond = ((vy < py && yj >= py) || (yj < py && vy >= py)) &&
                (vx <= px || xj <= px);

  // control of the stages
  always_ff @(posedge clk) begin
    if (rst) begin
      e1_vld <= 1'b0;
      e2_vld <= 1'b0;
      odd    <= 1'b0;
      done   <= 1'b0;
    end else begin
      e1_vld <= ctl.vld && !ctl.first;
      e2_vld <= e1_vld;
      done   <= e2_vld && e2_last;
      if (e2_vld) begin
        if (e2_last) begin
          odd  <= 1'b0;
        end else begin
          odd <= odd ^ tog;
        end
      end
    end
  end

  // edge operands, products
  always_ff @(posedge clk) begin
    if (ctl.vld) begin
      xj <= vx;
      yj <= vy;
    end
    e1_last <= ctl.last;
    e1_cond <= cond;
    e1_dpos <= yj > vy;
    e1_dneg <= yj < vy;
    e1_a    <= DW'(py) - DW'(vy);
    e1_b    <= DW'(xj) - DW'(vx);
    e1_c    <= DW'(px) - DW'(vx);
    e1_d    <= DW'(yj) - DW'(vy);
    e2_last <= e1_last;
    e2_cond <= e1_cond;
    e2_dpos <= e1_dpos;
    e2_dneg <= e1_dneg;
    e2_p1   <= e1_a * e1_b;
    e2_p2   <= e1_c * e1_d;
    if (e2_vld && e2_last) begin
      hit <= odd ^ tog;
    end
  end

  // crossing lies strictly left of the point
  assign tog = e2_cond && ((e2_dpos && e2_p1 < e2_p2) || (e2_dneg && e2_p1 > e2_p2));

endmodule

/* verif/polygon_hit_test_core_test.sv */
// testbench for polygon_hit_test_core: self-checking stream test against a predictor
`timescale 1ns / 100ps

module polygon_hit_test_core_test;

  localparam int NVERT = 16;
  localparam logic [2:0] KIND_SPARE_LO = 3'd5;
  localparam logic [2:0] KIND_SPARE_HI = 3'd7;

  typedef struct {
    logic       hit;
    logic [1:0] status;
    logic [4:0] count;
  } hit_result_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [63:0] s_tdata;
  logic [3:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  // predictor state: offsets, counts and positions (index 0 is A, 1 is B)
  logic signed [15:0] poly_x [2][NVERT];
  logic signed [15:0] poly_y [2][NVERT];
  int                 poly_n [2];
  logic signed [15:0] pos_x [2];
  logic signed [15:0] pos_y [2];

  hit_result_t pending_results[$];
  int          fail_count;
  bit          sender_idles;
  bit          receiver_idles;
  bit          hold_request;

  polygon_hit_test_core dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // clock
  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // saturate to the 16-bit coordinate range
  function automatic logic signed [15:0] clamp16(longint v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return v[15:0];
  endfunction

  // crossing-number test of an absolute point against one polygon
  function automatic bit crosses_odd(int sel, longint x, longint y);
    longint xi, xj, yi, yj, d, lhs, rhs;
    int n, j;
    bit odd;
    n = poly_n[sel];
    odd = 0;
    for (int i = 0; i < n; i++) begin
      j = (i == 0) ? n - 1 : i - 1;
      xi = longint'(poly_x[sel][i]) + pos_x[sel];
      xj = longint'(poly_x[sel][j]) + pos_x[sel];
      yi = longint'(poly_y[sel][i]) + pos_y[sel];
      yj = longint'(poly_y[sel][j]) + pos_y[sel];
      if (((yi < y && yj >= y) || (yj < y && yi >= y)) && (xi <= x || xj <= x)) begin
        d = yj - yi;
        lhs = (y - yi) * (xj - xi);
        rhs = (x - xi) * d;
        if ((d > 0 && lhs < rhs) || (d < 0 && lhs > rhs)) odd = !odd;
      end
    end
    return odd;
  endfunction

  // any vertex of polygon src inside polygon dst
  function automatic bit vertex_inside(int src, int dst);
    for (int k = 0; k < poly_n[src]; k++)
      if (crosses_odd(dst, longint'(poly_x[src][k]) + pos_x[src],
                      longint'(poly_y[src][k]) + pos_y[src])) return 1;
    return 0;
  endfunction

  // apply one command to the predictor state and return its result
  function automatic hit_result_t predict_hit_step(logic [2:0] kind, logic sel,
                                                   logic signed [15:0] cx,
                                                   logic signed [15:0] cy,
                                                   logic signed [15:0] cs,
                                                   logic signed [15:0] sn);
    hit_result_t r;
    longint x, y;
    r.hit = 0;
    r.status = phc_pkg::STAT_OK;
    case (kind)
      phc_pkg::KIND_APPEND: begin
        if (poly_n[sel] >= NVERT) r.status = phc_pkg::STAT_FULL;
        else begin
          poly_x[sel][poly_n[sel]] = cx;
          poly_y[sel][poly_n[sel]] = cy;
          poly_n[sel]++;
        end
      end
      phc_pkg::KIND_REMOVE: begin
        if (poly_n[sel] == 0) r.status = phc_pkg::STAT_EMPTY;
        else poly_n[sel]--;
      end
      phc_pkg::KIND_ROTATE: begin
        for (int k = 0; k < poly_n[sel]; k++) begin
          x = poly_x[sel][k];
          y = poly_y[sel][k];
          poly_x[sel][k] = clamp16((x * cs - y * sn + 8192) >>> 14);
          poly_y[sel][k] = clamp16((x * sn + y * cs + 8192) >>> 14);
        end
      end
      phc_pkg::KIND_POINT: r.hit = crosses_odd(sel, cx, cy);
      phc_pkg::KIND_COLLIDE: r.hit = vertex_inside(1, 0) || vertex_inside(0, 1);
      default: ;
    endcase
    r.count = poly_n[sel][4:0];
    return r;
  endfunction

  // send one command and record its expected result on transfer
  task automatic send_command(logic [2:0] kind, logic sel, logic signed [15:0] cx,
                              logic signed [15:0] cy, logic signed [15:0] cs = 16'sd16384,
                              logic signed [15:0] sn = 16'sd0);
    int gap;
    hit_result_t exp_item;
    if (sender_idles && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 12);
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser <= {sel, kind};
    s_tdata <= {sn, cs, cy, cx};
    do @(posedge clk); while (!s_tready);
    exp_item = predict_hit_step(kind, sel, cx, cy, cs, sn);
    pending_results.insert(pending_results.size(), exp_item);
  endtask

  task automatic stop_sending();
    @(negedge clk);
    s_tvalid <= 1'b0;
  endtask

  // wait until every expected result has come back
  task automatic drain_results();
    stop_sending();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_register(logic [1:0] idx, logic signed [15:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      phc_pkg::REG_POS_A_X: pos_x[0] = value;
      phc_pkg::REG_POS_A_Y: pos_y[0] = value;
      phc_pkg::REG_POS_B_X: pos_x[1] = value;
      phc_pkg::REG_POS_B_Y: pos_y[1] = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_positions(logic signed [15:0] ax, logic signed [15:0] ay,
                               logic signed [15:0] bx, logic signed [15:0] by);
    drain_results();
    write_register(phc_pkg::REG_POS_A_X, ax);
    write_register(phc_pkg::REG_POS_A_Y, ay);
    write_register(phc_pkg::REG_POS_B_X, bx);
    write_register(phc_pkg::REG_POS_B_Y, by);
  endtask

  // mostly small offsets so polygons overlap, sometimes the full range
  function automatic logic signed [15:0] pick_coord(int spread);
    if ($urandom_range(0, 9) == 0) return 16'($urandom);
    return 16'($urandom_range(0, 2 * spread) - spread);
  endfunction

  // directed: empty polygons, extremes, every command kind and two unused codes, full and empty cases
  task automatic test_directed();
    send_command(phc_pkg::KIND_POINT, 0, 0, 0);
    send_command(phc_pkg::KIND_REMOVE, 1, 0, 0);
    send_command(phc_pkg::KIND_COLLIDE, 0, 0, 0);
    send_command(KIND_SPARE_LO, 1, 16'sd5, 16'sd5);
    send_command(KIND_SPARE_HI, 0, -16'sd1, -16'sd1, -16'sd1, -16'sd1);
    send_command(phc_pkg::KIND_APPEND, 0, -16'sd160, -16'sd160);
    send_command(phc_pkg::KIND_APPEND, 0, 16'sd160, -16'sd160);
    send_command(phc_pkg::KIND_APPEND, 0, 16'sd160, 16'sd160);
    send_command(phc_pkg::KIND_APPEND, 0, -16'sd160, 16'sd160);
    send_command(phc_pkg::KIND_POINT, 0, 16'sd0, 16'sd0);
    send_command(phc_pkg::KIND_POINT, 0, 16'sd160, 16'sd0);
    send_command(phc_pkg::KIND_POINT, 0, 16'sd500, 16'sd0);
    send_command(phc_pkg::KIND_APPEND, 1, 16'sd100, 16'sd20);
    send_command(phc_pkg::KIND_APPEND, 1, 16'sd32767, -16'sd32768);
    send_command(phc_pkg::KIND_APPEND, 1, -16'sd32768, 16'sd32767);
    send_command(phc_pkg::KIND_COLLIDE, 1, 0, 0);
    send_command(phc_pkg::KIND_ROTATE, 0, 0, 0, 16'sd0, 16'sd16384);
    send_command(phc_pkg::KIND_ROTATE, 1, 0, 0, -16'sd16384, 16'sd0);
    send_command(phc_pkg::KIND_ROTATE, 1, 0, 0, 16'sd16384, -16'sd16384);
    send_command(phc_pkg::KIND_POINT, 1, 16'sd50, 16'sd10);
    // fill A to the limit, then append twice more
    for (int k = 0; k < 13; k++)
      send_command(phc_pkg::KIND_APPEND, 0, pick_coord(300), pick_coord(300));
    send_command(phc_pkg::KIND_APPEND, 0, 16'sd1, 16'sd1);
    send_command(phc_pkg::KIND_COLLIDE, 0, 0, 0);
  endtask

  // random commands, weighted toward building polygons and testing near them
  task automatic test_random(int items, int spread);
    int roll, sel, a;
    real ang;
    for (int n = 0; n < items; n++) begin
      roll = $urandom_range(0, 99);
      sel = $urandom_range(0, 1);
      if (roll < 34)
        send_command(phc_pkg::KIND_APPEND, 1'(sel), pick_coord(spread), pick_coord(spread));
      else if (roll < 48)
        send_command(phc_pkg::KIND_REMOVE, 1'(sel), 16'($urandom), 16'($urandom));
      else if (roll < 58) begin
        if ($urandom_range(0, 3) == 0)
          send_command(phc_pkg::KIND_ROTATE, 1'(sel), 16'($urandom), 16'($urandom),
                       16'($urandom_range(0, 32768) - 16384),
                       16'($urandom_range(0, 32768) - 16384));
        else begin
          a = $urandom_range(0, 359);
          ang = a * 3.14159265358979 / 180.0;
          send_command(phc_pkg::KIND_ROTATE, 1'(sel), 0, 0,
                       16'($rtoi($floor(16384.0 * $cos(ang) + 0.5))),
                       16'($rtoi($floor(16384.0 * $sin(ang) + 0.5))));
        end
      end
      else if (roll < 88)
        send_command(phc_pkg::KIND_POINT, 1'(sel),
                     clamp16(longint'(pos_x[sel]) + pick_coord(spread)),
                     clamp16(longint'(pos_y[sel]) + pick_coord(spread)));
      else if (roll < 96)
        send_command(phc_pkg::KIND_COLLIDE, 1'(sel), 16'($urandom), 16'($urandom));
      else send_command(3'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI)), 1'(sel),
                        16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    end
  endtask

  // receiver holds off while the sender keeps offering
  task automatic test_backpressure();
    hold_request = 1;
    for (int k = 0; k < 24; k++)
      send_command(k % 3 == 0 ? phc_pkg::KIND_POINT : phc_pkg::KIND_APPEND, 1'(k % 2),
                   pick_coord(200), pick_coord(200));
  endtask

  // receiver: random stall bursts and one long hold-off on request
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        m_tready <= 1'b0;
        repeat (400) @(negedge clk);
        hold_request = 0;
      end else if (receiver_idles && $urandom_range(0, 7) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(0, 11)) @(negedge clk);
      end else m_tready <= 1'b1;
    end
  end

  // compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    hit_result_t exp_r;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result transfer %h", $realtime, m_tdata);
        fail_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (m_tdata[0] !== exp_r.hit || m_tdata[2:1] !== exp_r.status ||
            m_tdata[7:3] !== exp_r.count) begin
          $display("%0t: mismatch expected hit %0d status %0d count %0d, actual hit %0d status %0d count %0d",
                   $realtime, exp_r.hit, exp_r.status, exp_r.count,
                   m_tdata[0], m_tdata[2:1], m_tdata[7:3]);
          fail_count++;
        end
      end
    end
  end

  // run limit
  initial begin
    #60ms;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    fail_count = 0;
    sender_idles = 1;
    receiver_idles = 1;
    hold_request = 0;
    poly_n[0] = 0;
    poly_n[1] = 0;
    pos_x[0] = 0; pos_y[0] = 0; pos_x[1] = 0; pos_y[1] = 0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_random(330, 400);
    set_positions(16'sd32767, -16'sd32768, -16'sd32768, 16'sd32767);
    test_random(200, 600);
    set_positions(-16'sd1200, 16'sd800, -16'sd1100, 16'sd900);
    test_backpressure();
    test_random(330, 500);
    set_positions(16'($urandom_range(0, 400)), 16'($urandom_range(0, 400)),
                  16'($urandom_range(0, 400)), 16'($urandom_range(0, 400)));
    sender_idles = 0;
    receiver_idles = 0;
    test_random(250, 500);

    drain_results();
    repeat (900) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
